>>> rtl/core/lpfc_pkg.sv
// ----------------------------------------------------------------------------
// lpfc_pkg: shared types and constants of the frame checker
// Region and status codes, parser phases, configuration indexes, and
// Adler-32 constants.
// ----------------------------------------------------------------------------
package lpfc_pkg;

  localparam int unsigned CFG_W = 27;        // width of the length limits
  localparam int unsigned CNT_W = 27;        // byte counter inside a frame
  localparam int unsigned LEN_W = 32;        // length and name length fields
  localparam int unsigned SUM_W = 16;        // one Adler-32 half

  localparam logic [SUM_W-1:0] ADLER_MOD   = 16'd65521;
  localparam logic [LEN_W-1:0] MIN_LEN     = 32'd8;    // absolute floor on L
  localparam logic [LEN_W-1:0] MIN_NAMELEN = 32'd2;    // one char plus zero
  localparam logic [CFG_W-1:0] MIN_LEN_RST = 27'd10;
  localparam logic [CFG_W-1:0] MAX_LEN_RST = 27'd67108864;
  localparam logic [CNT_W-1:0] HDR_BYTES   = 27'd4;    // bytes per 32-bit field
  localparam logic [CNT_W-1:0] HDR_LAST    = 27'd3;    // last byte of a field
  localparam logic [CNT_W-1:0] NAME_OVH    = 27'd8;    // name length plus sum

  typedef enum logic [1:0] {
    PH_LENGTH,
    PH_BODY,
    PH_DISCARD
  } phase_e;

  typedef enum logic [2:0] {
    REG_LENGTH    = 3'd0,
    REG_NAMELEN   = 3'd1,
    REG_NAME_CHAR = 3'd2,
    REG_NAME_ZERO = 3'd3,
    REG_PAYLOAD   = 3'd4,
    REG_CHECKSUM  = 3'd5,
    REG_DISCARD   = 3'd6
  } region_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LEN  = 2'd1,
    ST_BAD_SUM  = 2'd2,
    ST_BAD_NAME = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    CFG_MIN_LEN = 1'b0,
    CFG_MAX_LEN = 1'b1
  } cfg_idx_e;

  // one result beat
  typedef struct packed {
    logic [7:0] byte_value;
    region_e    region;
    logic       frame_end;
    status_e    status;
  } res_t;

  // Adler-32 running sums
  typedef struct packed {
    logic [SUM_W-1:0] high;
    logic [SUM_W-1:0] low;
  } adler_t;

endpackage

>>> rtl/core/lpfc_stream_if.sv
// ----------------------------------------------------------------------------
// lpfc stream interfaces: valid/ready channels of the frame checker
// Byte input channel and tagged result channel.
// ----------------------------------------------------------------------------
interface lpfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface lpfc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic [2:0] region;
  logic       frame_end;
  logic [1:0] status;

  modport source (output valid, output byte_value, output region,
                  output frame_end, output status, input ready);
  modport sink   (input valid, input byte_value, input region,
                  input frame_end, input status, output ready);
endinterface

>>> rtl/core/lpfc_adler.sv
// ----------------------------------------------------------------------------
// lpfc_adler: one-byte Adler-32 update
// Adds a byte to the low sum and the new low sum to the high sum, each
// reduced modulo 65521 by one conditional subtract.
// ----------------------------------------------------------------------------
module lpfc_adler (
  input  lpfc_pkg::adler_t sum_i,
  input  logic [7:0]       byte_i,
  output lpfc_pkg::adler_t sum_o
);
  import lpfc_pkg::*;

  logic [SUM_W:0] low_raw;
  logic [SUM_W:0] high_raw;
  logic [SUM_W:0] mod_ext;

  assign mod_ext = {1'b0, ADLER_MOD};

  // low sum first, both operands below the modulus; high sum takes the
  // updated low sum
  always_comb begin
    low_raw = {1'b0, sum_i.low} + {{(SUM_W-7){1'b0}}, byte_i};
    if (low_raw >= mod_ext) begin
      low_raw = low_raw - mod_ext;
    end
    sum_o.low = low_raw[SUM_W-1:0];

    high_raw = {1'b0, sum_i.high} + {1'b0, sum_o.low};
    if (high_raw >= mod_ext) begin
      high_raw = high_raw - mod_ext;
    end
    sum_o.high = high_raw[SUM_W-1:0];
  end

endmodule

>>> rtl/core/lpfc_frame_fsm.sv
// ----------------------------------------------------------------------------
// lpfc_frame_fsm: frame parser state and byte classification
// Tracks the frame phase and position, checks the length fields, runs the
// checksum and forms the result of each byte it is stepped with.
// ----------------------------------------------------------------------------
module lpfc_frame_fsm (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic [7:0]                    byte_i,
  input  logic [lpfc_pkg::CFG_W-1:0]    min_len_i,
  input  logic [lpfc_pkg::CFG_W-1:0]    max_len_i,
  output lpfc_pkg::res_t                res_o
);
  import lpfc_pkg::*;

  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] nl_q, nl_d;
  adler_t           sum_q, sum_d;
  adler_t           sum_upd;
  logic [LEN_W-1:0] rsum_q, rsum_d;
  logic             nl_bad_q, nl_bad_d;

  logic [CNT_W-1:0] len_lo;
  logic [CNT_W-1:0] sum_start;
  logic [CNT_W-1:0] nl_max;
  logic [CNT_W-1:0] name_pos;
  logic [CNT_W-1:0] name_last;
  logic [CNT_W-1:0] cnt_inc;

  lpfc_adler u_adler (
    .sum_i  (sum_q),
    .byte_i (byte_i),
    .sum_o  (sum_upd)
  );

  // frame geometry, valid once the length is accepted
  assign len_lo    = len_q[CNT_W-1:0];
  assign sum_start = len_lo - HDR_BYTES;
  assign nl_max    = len_lo - NAME_OVH;
  assign name_pos  = cnt_q - HDR_BYTES;
  assign name_last = nl_q[CNT_W-1:0] - 27'd1;
  assign cnt_inc   = cnt_q + 27'd1;

  // next state and result
  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    len_d    = len_q;
    nl_d     = nl_q;
    sum_d    = sum_q;
    rsum_d   = rsum_q;
    nl_bad_d = nl_bad_q;

    res_o.byte_value = byte_i;
    res_o.region     = REG_DISCARD;
    res_o.frame_end  = 1'b0;
    res_o.status     = ST_OK;

    unique case (phase_q)
      PH_LENGTH: begin
        res_o.region = REG_LENGTH;
        len_d        = {len_q[LEN_W-9:0], byte_i};
        cnt_d        = cnt_inc;
        if (cnt_q == HDR_LAST) begin
          cnt_d = '0;
          if (len_d[LEN_W-1] || len_d < MIN_LEN ||
              len_d < {{(LEN_W-CFG_W){1'b0}}, min_len_i} ||
              len_d > {{(LEN_W-CFG_W){1'b0}}, max_len_i}) begin
            res_o.frame_end = 1'b1;
            res_o.status    = ST_BAD_LEN;
            phase_d         = PH_DISCARD;
          end else begin
            phase_d = PH_BODY;
          end
        end
      end

      PH_BODY: begin
        cnt_d = cnt_inc;
        if (cnt_q < HDR_BYTES) begin
          // name length field, covered by the checksum
          res_o.region = REG_NAMELEN;
          sum_d        = sum_upd;
          nl_d         = {nl_q[LEN_W-9:0], byte_i};
          if (cnt_q == HDR_LAST) begin
            nl_bad_d = nl_d[LEN_W-1] || nl_d < MIN_NAMELEN ||
                       nl_d > {{(LEN_W-CNT_W){1'b0}}, nl_max};
          end
        end else if (cnt_q < sum_start) begin
          // name and payload
          sum_d = sum_upd;
          if (nl_bad_q) begin
            res_o.region = REG_PAYLOAD;
          end else if (name_pos < name_last) begin
            res_o.region = REG_NAME_CHAR;
          end else if (name_pos == name_last) begin
            res_o.region = REG_NAME_ZERO;
          end else begin
            res_o.region = REG_PAYLOAD;
          end
        end else begin
          res_o.region = REG_CHECKSUM;
          rsum_d       = {rsum_q[LEN_W-9:0], byte_i};
        end

        // last byte of the frame: report and rearm for the next one
        if (cnt_inc == len_lo) begin
          res_o.frame_end = 1'b1;
          if ({sum_q.high, sum_q.low} != rsum_d) begin
            res_o.status = ST_BAD_SUM;
          end else if (nl_bad_q) begin
            res_o.status = ST_BAD_NAME;
          end else begin
            res_o.status = ST_OK;
          end
          phase_d  = PH_LENGTH;
          cnt_d    = '0;
          len_d    = '0;
          nl_d     = '0;
          sum_d    = '{high: '0, low: 16'd1};
          rsum_d   = '0;
          nl_bad_d = 1'b0;
        end
      end

      PH_DISCARD: begin
        res_o.region = REG_DISCARD;
      end

      default: begin
        res_o.region = REG_DISCARD;
      end
    endcase
  end

  // state registers, stepped once per beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_LENGTH;
      cnt_q    <= '0;
      len_q    <= '0;
      nl_q     <= '0;
      sum_q    <= '{high: '0, low: 16'd1};
      rsum_q   <= '0;
      nl_bad_q <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      len_q    <= len_d;
      nl_q     <= nl_d;
      sum_q    <= sum_d;
      rsum_q   <= rsum_d;
      nl_bad_q <= nl_bad_d;
    end
  end

  // checks
  a_low_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q.low < ADLER_MOD) else $error("adler low sum not reduced");

  a_high_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q.high < ADLER_MOD) else $error("adler high sum not reduced");

  a_discard_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DISCARD |=> phase_q == PH_DISCARD)
    else $error("left discard without reset");

  a_body_len_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BODY |-> (len_q >= MIN_LEN && len_q[LEN_W-1:CNT_W] == '0 &&
                            cnt_q < len_lo))
    else $error("body phase with bad length or position");

endmodule

>>> rtl/core/length_prefixed_frame_checker.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_checker: top level of the frame checker
// Input register, frame parser, result register and length limit registers.
// ----------------------------------------------------------------------------
// Usage:
//   byte_i carries the received stream, one byte per beat. result_o returns
//   one beat per input beat, in order: the byte, its region tag, and on the
//   last byte of a frame (or of a rejected length) frame_end with status.
//   cfg_we_i/cfg_idx_i/cfg_data_i write the length limits: index 0 is the
//   minimum, index 1 the maximum frame length; write while the block is idle.
// Pipeline and throughput:
//   A byte accepted into the input register is classified combinationally
//   and is captured in the result register when the input stage steps, so a
//   stall can hold it in the input register. One byte per cycle is sustained
//   while result_o is taken; the single Adler-32 update path (two adds with
//   conditional subtracts) lies between the input and result registers.
// Reset:
//   Clears both pipeline stages, rearms the parser at the length field and
//   loads the limits with 10 and 67108864. A rejected length makes every
//   following byte tag as discarded until the next reset.
// Stall:
//   When result_o is not taken the result register holds and the input
//   register fills; byte_i.ready drops only when both are full.
// ----------------------------------------------------------------------------
module length_prefixed_frame_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  lpfc_in_if.sink                    byte_i,
  lpfc_out_if.source                 result_o,
  input  logic                       cfg_we_i,
  input  lpfc_pkg::cfg_idx_e         cfg_idx_i,
  input  logic [lpfc_pkg::CFG_W-1:0] cfg_data_i
);
  import lpfc_pkg::*;

  logic             in_vld_q;
  logic [7:0]       in_byte_q;
  logic             step;
  logic             out_vld_q;
  res_t             res_q;
  res_t             res_d;
  logic [CFG_W-1:0] min_len_q;
  logic [CFG_W-1:0] max_len_q;

  // the input stage moves on when the result register is free or drains
  assign step         = in_vld_q && (!out_vld_q || result_o.ready);
  assign byte_i.ready = !in_vld_q || step;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (byte_i.ready) begin
      in_vld_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      in_byte_q <= byte_i.data_byte;
    end
  end

  lpfc_frame_fsm u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .byte_i    (in_byte_q),
    .min_len_i (min_len_q),
    .max_len_i (max_len_q),
    .res_o     (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (result_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid      = out_vld_q;
  assign result_o.byte_value = res_q.byte_value;
  assign result_o.region     = res_q.region;
  assign result_o.frame_end  = res_q.frame_end;
  assign result_o.status     = res_q.status;

  // length limit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MIN_LEN_RST;
      max_len_q <= MAX_LEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_LEN: min_len_q <= cfg_data_i;
        CFG_MAX_LEN: max_len_q <= cfg_data_i;
        default:     min_len_q <= min_len_q;
      endcase
    end
  end

  // checks
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !result_o.ready) |-> !step)
    else $error("result overwritten while stalled");

  a_step_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_vld_q) else $error("stepped beat lost");

  a_end_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !res_q.frame_end) |-> res_q.status == ST_OK)
    else $error("status set without frame end");

endmodule
